[sv/ptc_pkg.sv]
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, widths and the step program for the compensation sequencer.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int ACC_W  = 128;
    localparam int MUL_W  = 33;
    localparam int COEF_W = 18;
    localparam int PC_W   = 5;
    localparam int SH_W   = 7;
    localparam int CNT_W  = $clog2(MUL_W);
    localparam int CAL_W  = 168;

    localparam logic [PC_W-1:0] PC_PRES = PC_W'(0);
    localparam logic [PC_W-1:0] PC_TEMP = PC_W'(14);

    localparam logic [1:0] CFG_LOW  = 2'd0;
    localparam logic [1:0] CFG_MID  = 2'd1;
    localparam logic [1:0] CFG_HIGH = 2'd2;

    typedef enum logic [1:0] {M_NONE, M_T, M_R, M_D} t_msel;

    typedef enum logic [3:0] {
        C_ZERO, C_T2, C_T3, C_P1, C_P2, C_P3, C_P4, C_P5,
        C_P6, C_P7, C_P8, C_P9, C_P10, C_P11
    } t_coef;

    typedef struct packed {
        t_msel           msel;
        logic            clr;
        t_coef           coef;
        logic [SH_W-1:0] sh;
        logic            add_hold;
        logic            store_hold;
        logic            last;
    } t_instr;

    // Pressure runs nested Horner in t and r; temperature is (T3*d + T2<<18)*d.
    function automatic t_instr ptc_instr(input logic [PC_W-1:0] pc);
        t_instr s;
        s = '{M_NONE, 1'b0, C_ZERO, 7'd0, 1'b0, 1'b0, 1'b1};
        unique case (pc)
            5'd0:  s = '{M_NONE, 1'b1, C_P11, 7'd20, 1'b0, 1'b0, 1'b0};
            5'd1:  s = '{M_R,    1'b0, C_ZERO, 7'd0, 1'b0, 1'b1, 1'b0};
            5'd2:  s = '{M_NONE, 1'b1, C_P10, 7'd21, 1'b0, 1'b0, 1'b0};
            5'd3:  s = '{M_T,    1'b0, C_P9,  7'd37, 1'b1, 1'b0, 1'b0};
            5'd4:  s = '{M_R,    1'b0, C_ZERO, 7'd0, 1'b0, 1'b1, 1'b0};
            5'd5:  s = '{M_NONE, 1'b1, C_P4,  7'd0,  1'b0, 1'b0, 1'b0};
            5'd6:  s = '{M_T,    1'b0, C_P3,  7'd21, 1'b0, 1'b0, 1'b0};
            5'd7:  s = '{M_T,    1'b0, C_P2,  7'd40, 1'b0, 1'b0, 1'b0};
            5'd8:  s = '{M_T,    1'b0, C_P1,  7'd65, 1'b1, 1'b0, 1'b0};
            5'd9:  s = '{M_R,    1'b0, C_ZERO, 7'd0, 1'b0, 1'b1, 1'b0};
            5'd10: s = '{M_NONE, 1'b1, C_P8,  7'd22, 1'b0, 1'b0, 1'b0};
            5'd11: s = '{M_T,    1'b0, C_P7,  7'd45, 1'b0, 1'b0, 1'b0};
            5'd12: s = '{M_T,    1'b0, C_P6,  7'd63, 1'b0, 1'b0, 1'b0};
            5'd13: s = '{M_T,    1'b0, C_P5,  7'd88, 1'b1, 1'b0, 1'b1};
            5'd14: s = '{M_NONE, 1'b1, C_T3,  7'd0,  1'b0, 1'b0, 1'b0};
            5'd15: s = '{M_D,    1'b0, C_T2,  7'd18, 1'b0, 1'b0, 1'b0};
            5'd16: s = '{M_D,    1'b0, C_ZERO, 7'd0, 1'b0, 1'b0, 1'b1};
            default: s = '{M_NONE, 1'b0, C_ZERO, 7'd0, 1'b0, 1'b0, 1'b1};
        endcase
        return s;
    endfunction

endpackage

[sv/ptc_if.sv]
// ----------------------------------------------------------------------------
// ptc_in_if / ptc_out_if
// Valid/ready channels for raw samples and compensated results.
// ----------------------------------------------------------------------------
interface ptc_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [23:0] raw_sample;
    modport source (output valid, output action, output raw_sample, input ready);
    modport sink   (input valid, input action, input raw_sample, output ready);
endinterface

interface ptc_out_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [31:0] value;
    logic               saturated;
    modport source (output valid, output kind, output value, output saturated, input ready);
    modport sink   (input valid, input kind, input value, input saturated, output ready);
endinterface

[sv/pressure_temperature_compensation_unit.sv]
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_unit
// Barometric calibration polynomials in exact 128-bit fixed point.
// ----------------------------------------------------------------------------
// One sample at a time. A step sequencer runs Horner steps on a 128-bit
// accumulator. A step without a multiply completes in the S_STEP state. A step
// with a multiply is issued in S_STEP, runs in the bit-serial multiplier while
// the sequencer waits in S_MUL, and completes when the multiplier signals done.
// A temperature sample has one plain step and two multiply steps. A pressure
// sample has four plain steps and ten multiply steps. The sample input is ready
// again in the cycle the result appears, so a new request is taken while the
// previous result still waits at the output. A finished result waits in the
// done state for as long as the output holds an earlier result that is not yet
// taken.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    ptc_in_if.sink      i_smp,
    ptc_out_if.source   o_res
);
    import ptc_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_STEP, S_MUL, S_DONE} t_state;

    t_state              r_state;
    logic [CAL_W-1:0]    r_cal;
    logic [PC_W-1:0]     r_pc;
    logic                r_kind;
    logic [23:0]         r_raw;
    logic [MUL_W-1:0]    r_d;
    logic [ACC_W-1:0]    r_acc;
    logic [ACC_W-1:0]    r_hold;
    logic signed [31:0]  r_temp;
    logic                r_ovalid;
    logic                r_okind;
    logic signed [31:0]  r_ovalue;
    logic                r_osat;

    t_instr                     w_ins;
    logic signed [COEF_W-1:0]   w_coef;
    logic [ACC_W-1:0]           w_k;
    logic [ACC_W-1:0]           w_base;
    logic [ACC_W-1:0]           w_fin;
    logic [MUL_W-1:0]           w_b;
    logic                       w_start;
    logic                       w_mdone;
    logic [ACC_W-1:0]           w_mp;
    logic signed [50:0]         w_q;
    logic                       w_psat;
    logic signed [31:0]         w_pval;

    assign w_ins = ptc_instr(r_pc);

    always_comb begin
        case (w_ins.coef)
            C_T2:    w_coef = COEF_W'({1'b0, r_cal[31:16]});
            C_T3:    w_coef = COEF_W'($signed(r_cal[39:32]));
            C_P1:    w_coef = COEF_W'($signed(r_cal[55:40])) - COEF_W'(16384);
            C_P2:    w_coef = COEF_W'($signed(r_cal[71:56])) - COEF_W'(16384);
            C_P3:    w_coef = COEF_W'($signed(r_cal[79:72]));
            C_P4:    w_coef = COEF_W'($signed(r_cal[87:80]));
            C_P5:    w_coef = COEF_W'({1'b0, r_cal[103:88]});
            C_P6:    w_coef = COEF_W'({1'b0, r_cal[119:104]});
            C_P7:    w_coef = COEF_W'($signed(r_cal[127:120]));
            C_P8:    w_coef = COEF_W'($signed(r_cal[135:128]));
            C_P9:    w_coef = COEF_W'($signed(r_cal[151:136]));
            C_P10:   w_coef = COEF_W'($signed(r_cal[159:152]));
            C_P11:   w_coef = COEF_W'($signed(r_cal[167:160]));
            default: w_coef = '0;
        endcase
    end

    assign w_k    = ACC_W'(w_coef) << w_ins.sh;
    assign w_base = (r_state == S_MUL) ? w_mp : (w_ins.clr ? '0 : r_acc);
    assign w_fin  = w_base + w_k + (w_ins.add_hold ? r_hold : '0);

    always_comb begin
        case (w_ins.msel)
            M_T:     w_b = MUL_W'(r_temp);
            M_R:     w_b = MUL_W'(r_raw);
            M_D:     w_b = r_d;
            default: w_b = '0;
        endcase
    end

    assign w_start = (r_state == S_STEP) && (w_ins.msel != M_NONE);

    ptc_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_a     (r_acc),
        .i_b     (w_b),
        .o_done  (w_mdone),
        .o_p     (w_mp)
    );

    assign w_q    = $signed(r_acc[127:77]);
    assign w_psat = (w_q > 51'sd2147483647) || (w_q < -51'sd2147483648);
    assign w_pval = w_psat ? (w_q[50] ? 32'sh80000000 : 32'sh7fffffff) : w_q[31:0];

    assign i_smp.ready     = (r_state == S_IDLE);
    assign o_res.valid     = r_ovalid;
    assign o_res.kind      = r_okind;
    assign o_res.value     = r_ovalue;
    assign o_res.saturated = r_osat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cal    <= '0;
            r_temp   <= '0;
            r_ovalid <= 1'b0;
            r_pc     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_LOW:  r_cal[63:0]    <= i_cfg_data;
                    CFG_MID:  r_cal[127:64]  <= i_cfg_data;
                    CFG_HIGH: r_cal[167:128] <= i_cfg_data[39:0];
                    default:  ;
                endcase
            end
            if (o_res.ready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_smp.valid) begin
                        r_kind  <= i_smp.action;
                        r_raw   <= i_smp.raw_sample;
                        r_d     <= MUL_W'(i_smp.raw_sample) - MUL_W'({r_cal[15:0], 8'd0});
                        r_pc    <= i_smp.action ? PC_PRES : PC_TEMP;
                        r_state <= S_STEP;
                    end
                end
                S_STEP, S_MUL: begin
                    if ((r_state == S_STEP && w_ins.msel == M_NONE) ||
                        (r_state == S_MUL && w_mdone)) begin
                        r_acc <= w_fin;
                        if (w_ins.store_hold) begin
                            r_hold <= w_fin;
                        end
                        r_pc    <= r_pc + PC_W'(1);
                        r_state <= w_ins.last ? S_DONE : S_STEP;
                    end else if (r_state == S_STEP) begin
                        r_state <= S_MUL;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || o_res.ready) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= r_kind;
                        if (r_kind) begin
                            r_ovalue <= w_pval;
                            r_osat   <= w_psat;
                        end else begin
                            r_ovalue <= $signed(r_acc[63:32]);
                            r_osat   <= 1'b0;
                            r_temp   <= $signed(r_acc[63:32]);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_smp.valid && i_smp.ready) |=> (r_state == S_STEP))
        else $error("request not started");
    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mdone |-> (r_state == S_MUL)) else $error("multiply done outside S_MUL");
    a_temp_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_okind) |-> !r_osat) else $error("temperature saturated");

endmodule

[sv/ptc_serial_mul.sv]
// ----------------------------------------------------------------------------
// ptc_serial_mul
// Bit-serial signed multiplier: one multiplier bit per cycle, wrapping product.
// ----------------------------------------------------------------------------
module ptc_serial_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ptc_pkg::ACC_W-1:0]  i_a,
    input  logic [ptc_pkg::MUL_W-1:0]  i_b,
    output logic                       o_done,
    output logic [ptc_pkg::ACC_W-1:0]  o_p
);
    import ptc_pkg::*;

    logic [ACC_W-1:0] r_a;
    logic [MUL_W-1:0] r_b;
    logic [ACC_W-1:0] r_p;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             w_last;

    assign w_last = (r_cnt == CNT_W'(MUL_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_p    <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // sign bit carries negative weight
                if (r_b[0]) begin
                    r_p <= w_last ? r_p - r_a : r_p + r_a;
                end
                r_a   <= r_a << 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt + CNT_W'(1);
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_p;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done while busy");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("start while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done held");

endmodule
